@@ hw/rtl/tsq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the two-stack queue.
package tsq_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IO_W        = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_MV_RD,
        S_MV_WR
    } state_t;

    typedef struct packed {
        logic    load;
        logic    push;
        logic    pop_rd;
        logic    mv_rd;
        logic    mv_wr;
        logic    respond;
        logic    use_pop;
        status_t rsp_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_deq;
        logic in_full;
        logic in_empty;
        logic out_empty;
    } dp_stat_t;

endpackage

@@ hw/rtl/tsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tsq_ctrl.sv @@
// Controller state machine: sequences pushes, pops and stack-to-stack transfers.
module tsq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tsq_pkg::dp_stat_t stat,
    output tsq_pkg::ctrl_cmd_t cmd
);

    tsq_pkg::state_t state_reg;
    tsq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = tsq_pkg::S_EXEC;
                end
            end
            tsq_pkg::S_EXEC:
            begin
                if (!stat.op_deq)
                begin
                    if (!stat.in_full || !stat.out_empty)
                    begin
                        state_next = tsq_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = tsq_pkg::S_MV_RD;
                    end
                end
                else
                begin
                    if (!stat.out_empty)
                    begin
                        state_next = tsq_pkg::S_POP;
                    end
                    else if (stat.in_empty)
                    begin
                        state_next = tsq_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = tsq_pkg::S_MV_RD;
                    end
                end
            end
            tsq_pkg::S_POP:
            begin
                state_next = tsq_pkg::S_IDLE;
            end
            tsq_pkg::S_MV_RD:
            begin
                state_next = tsq_pkg::S_MV_WR;
            end
            tsq_pkg::S_MV_WR:
            begin
                if (stat.in_empty)
                begin
                    state_next = tsq_pkg::S_EXEC;
                end
                else
                begin
                    state_next = tsq_pkg::S_MV_RD;
                end
            end
            default:
            begin
                state_next = tsq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.rsp_status = tsq_pkg::ST_DONE;
        busy           = 1'b1;
        unique case (state_reg)
            tsq_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            tsq_pkg::S_EXEC:
            begin
                if (!stat.op_deq)
                begin
                    if (!stat.in_full)
                    begin
                        cmd.push    = 1'b1;
                        cmd.respond = 1'b1;
                    end
                    else if (!stat.out_empty)
                    begin
                        cmd.respond    = 1'b1;
                        cmd.rsp_status = tsq_pkg::ST_FULL;
                    end
                end
                else
                begin
                    if (!stat.out_empty)
                    begin
                        cmd.pop_rd = 1'b1;
                    end
                    else if (stat.in_empty)
                    begin
                        cmd.respond    = 1'b1;
                        cmd.rsp_status = tsq_pkg::ST_EMPTY;
                    end
                end
            end
            tsq_pkg::S_POP:
            begin
                cmd.respond = 1'b1;
                cmd.use_pop = 1'b1;
            end
            tsq_pkg::S_MV_RD:
            begin
                cmd.mv_rd = 1'b1;
            end
            tsq_pkg::S_MV_WR:
            begin
                cmd.mv_wr = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ hw/rtl/tsq_dp.sv @@
// Datapath: stack memories, stack counters, request latch and result registers.
module tsq_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tsq_pkg::ctrl_cmd_t        cmd,
    output tsq_pkg::dp_stat_t         stat,
    input  logic                      func,
    input  logic signed [31:0]        data_in,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [31:0]        data_out,
    output logic                      queue_empty
);

    logic [tsq_pkg::CNT_W-1:0]      in_cnt_reg;
    logic [tsq_pkg::CNT_W-1:0]      in_cnt_next;
    logic [tsq_pkg::CNT_W-1:0]      out_cnt_reg;
    logic [tsq_pkg::CNT_W-1:0]      out_cnt_next;
    logic [tsq_pkg::CNT_W-1:0]      in_top;
    logic [tsq_pkg::CNT_W-1:0]      out_top;
    logic                           op_reg;
    logic                           op_next;
    logic [tsq_pkg::DATA_WIDTH-1:0] data_reg;
    logic [tsq_pkg::DATA_WIDTH-1:0] data_next;
    logic [63:0]                    in_wide;
    logic [63:0]                    rd_wide;
    logic [tsq_pkg::DATA_WIDTH-1:0] in_rdata;
    logic [tsq_pkg::DATA_WIDTH-1:0] out_rdata;
    logic                           done_reg;
    tsq_pkg::status_t               status_reg;
    tsq_pkg::status_t               status_next;
    logic [tsq_pkg::IO_W-1:0]       dout_reg;
    logic [tsq_pkg::IO_W-1:0]       dout_next;
    logic                           qempty_reg;
    logic                           qempty_next;

    assign in_top  = in_cnt_reg - tsq_pkg::CNT_W'(1);
    assign out_top = out_cnt_reg - tsq_pkg::CNT_W'(1);

    tsq_ram #(
        .WIDTH (tsq_pkg::DATA_WIDTH),
        .DEPTH (tsq_pkg::STACK_DEPTH)
    ) u_in_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (in_cnt_reg[tsq_pkg::ADDR_W-1:0]),
        .wdata (data_reg),
        .re    (cmd.mv_rd),
        .raddr (in_top[tsq_pkg::ADDR_W-1:0]),
        .rdata (in_rdata)
    );

    tsq_ram #(
        .WIDTH (tsq_pkg::DATA_WIDTH),
        .DEPTH (tsq_pkg::STACK_DEPTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (cmd.mv_wr),
        .waddr (out_cnt_reg[tsq_pkg::ADDR_W-1:0]),
        .wdata (in_rdata),
        .re    (cmd.pop_rd),
        .raddr (out_top[tsq_pkg::ADDR_W-1:0]),
        .rdata (out_rdata)
    );

    always_comb
    begin
        in_cnt_next = in_cnt_reg;
        if (cmd.push)
        begin
            in_cnt_next = in_cnt_reg + tsq_pkg::CNT_W'(1);
        end
        else if (cmd.mv_rd)
        begin
            in_cnt_next = in_top;
        end

        out_cnt_next = out_cnt_reg;
        if (cmd.pop_rd)
        begin
            out_cnt_next = out_top;
        end
        else if (cmd.mv_wr)
        begin
            out_cnt_next = out_cnt_reg + tsq_pkg::CNT_W'(1);
        end
    end

    assign in_wide     = 64'(unsigned'(data_in));
    assign rd_wide     = 64'(out_rdata);
    assign op_next     = cmd.load ? func : op_reg;
    assign data_next   = cmd.load ? in_wide[tsq_pkg::DATA_WIDTH-1:0] : data_reg;
    assign status_next = cmd.respond ? cmd.rsp_status : status_reg;
    assign dout_next   = cmd.respond ? (cmd.use_pop ? rd_wide[tsq_pkg::IO_W-1:0] : '0)
                                     : dout_reg;
    assign qempty_next = cmd.respond ? ((in_cnt_next == '0) && (out_cnt_next == '0))
                                     : qempty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            done_reg    <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
        qempty_reg <= qempty_next;
    end

    assign stat.op_deq    = op_reg;
    assign stat.in_full   = (in_cnt_reg == tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH));
    assign stat.in_empty  = (in_cnt_reg == '0);
    assign stat.out_empty = (out_cnt_reg == '0);

    assign done        = done_reg;
    assign status      = status_reg;
    assign data_out    = dout_reg;
    assign queue_empty = qempty_reg;

    a_in_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_cnt_reg <= tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH))
        else $error("in-stack count out of range");

    a_out_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH))
        else $error("out-stack count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.in_full)
        else $error("push into full in-stack");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_rd |=> (cmd.respond && cmd.use_pop))
        else $error("pop read not followed by result");

    a_xfer_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mv_rd |=> (cmd.mv_wr && (out_cnt_reg != tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH))))
        else $error("transfer write missing or out-stack overflow");

endmodule

@@ hw/rtl/two_stack_queue.sv @@
// Top level of the two-stack queue: controller and datapath.
//
// A command is taken when start is high and busy is low; func 0 enqueues data_in, func 1
// dequeues. Every command yields exactly one result, shown for one cycle with done high:
// status (0 done, 1 full, 2 empty), data_out (dequeued value, else zero) and queue_empty.
// The result cannot be held off, so capture it on the done cycle. An enqueue's result is
// registered from the execute state, a dequeue's from the pop state after the out-stack read
// (an empty refusal from the execute state); busy is already low in the result cycle, so the
// next command can be accepted then. When the out-stack must be refilled, the whole in-stack
// is moved across first, each element read through the in-stack memory's registered read port
// and then written to the out-stack, before the command is re-run.
module two_stack_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [31:0] data_in,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] data_out,
    output logic               queue_empty
);

    tsq_pkg::ctrl_cmd_t cmd;
    tsq_pkg::dp_stat_t  stat;

    tsq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    tsq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .data_in     (data_in),
        .done        (done),
        .status      (status),
        .data_out    (data_out),
        .queue_empty (queue_empty)
    );

endmodule

@@ bench/two_stack_queue_tb.sv @@
// Self-checking testbench for the two-stack queue: directed corner cases, then random traffic.
`timescale 1ns / 1ps

module two_stack_queue_tb;

    localparam logic OP_ENQ    = 1'b0;
    localparam logic OP_DEQ    = 1'b1;
    localparam int   N_RANDOM  = 1350;
    localparam int   DRAIN     = 4 * tsq_pkg::STACK_DEPTH + 10;
    localparam int   LIMIT     = 400000;

    typedef struct {
        logic        op;
        logic [31:0] value;
    } cmd_t;

    typedef struct {
        tsq_pkg::status_t status;
        logic [31:0]      data;
        logic             empty;
    } qres_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        start    = 1'b0;
    logic        func     = 1'b0;
    logic [31:0] data_in  = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [31:0] data_out;
    logic        queue_empty;

    two_stack_queue DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .data_in     (data_in),
        .done        (done),
        .status      (status),
        .data_out    (data_out),
        .queue_empty (queue_empty)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow copy of both stacks
    logic [tsq_pkg::DATA_WIDTH-1:0] in_stk  [tsq_pkg::STACK_DEPTH];
    logic [tsq_pkg::DATA_WIDTH-1:0] out_stk [tsq_pkg::STACK_DEPTH];
    int in_cnt  = 0;
    int out_cnt = 0;

    int n_enq = 0, n_deq = 0, n_full = 0, n_empty = 0, n_moves = 0;
    int fail_cnt  = 0;
    int cycle_cnt = 0;

    cmd_t  pending_cmds[$];
    qres_t rsp_q[$];

    logic took       = 1'b0;
    int   burst_left = 1;
    int   gap_left   = 0;

    function automatic void shift_stacks();
        int n;
        n = 0;
        while (in_cnt > 0 && n < tsq_pkg::STACK_DEPTH)
        begin
            in_cnt--;
            out_stk[n] = in_stk[in_cnt];
            n++;
        end
        out_cnt = n;
        n_moves++;
    endfunction

    task automatic queue_op(input logic op, input logic [31:0] value, output qres_t r);
        r.status = tsq_pkg::ST_DONE;
        r.data   = '0;
        if (op == OP_ENQ)
        begin
            n_enq++;
            if (in_cnt < tsq_pkg::STACK_DEPTH)
            begin
                in_stk[in_cnt] = value;
                in_cnt++;
            end
            else if (out_cnt != 0)
            begin
                r.status = tsq_pkg::ST_FULL;
                n_full++;
            end
            else
            begin
                shift_stacks();
                in_stk[in_cnt] = value;
                in_cnt++;
            end
        end
        else
        begin
            n_deq++;
            if (out_cnt == 0)
            begin
                if (in_cnt == 0)
                begin
                    r.status = tsq_pkg::ST_EMPTY;
                    n_empty++;
                end
                else
                    shift_stacks();
            end
            if (r.status == tsq_pkg::ST_DONE && out_cnt > 0)
            begin
                out_cnt--;
                r.data = 32'(out_stk[out_cnt]);
            end
        end
        r.empty = (in_cnt == 0 && out_cnt == 0);
    endtask

    task automatic add_cmd(input logic op, input logic [31:0] value);
        cmd_t c;
        c.op    = op;
        c.value = value;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // driver: bursts of transfers separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || took)
            begin
                if (gap_left > 0 || pending_cmds.size() == 0)
                begin
                    start <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    start   <= 1'b1;
                    func    <= pending_cmds[0].op;
                    data_in <= pending_cmds[0].value;
                    pending_cmds.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                                  : $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor: check each result, then record the transfer taken at this edge
    always @(posedge clk)
    begin
        qres_t r;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n)
        begin
            took <= start && !busy;
            if (done)
            begin
                if (rsp_q.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("unexpected result: status=%0d data_out=%h queue_empty=%b",
                                 status, data_out, queue_empty);
                    fail_cnt++;
                end
                else
                begin
                    r = rsp_q.pop_front();
                    if (status !== r.status || data_out !== r.data || queue_empty !== r.empty)
                    begin
                        if (fail_cnt < 10)
                            $display("mismatch: exp status=%0d data_out=%h queue_empty=%b, %s%0d %h %b",
                                     r.status, r.data, r.empty, "got ",
                                     status, data_out, queue_empty);
                        fail_cnt++;
                    end
                end
            end
            if (start && !busy)
            begin
                queue_op(func, data_in, r);
                rsp_q.push_back(r);
            end
        end
    end

    initial
    begin
        wait (cycle_cnt >= LIMIT);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("two_stack_queue_tb: FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int enq_pct;
        int len;

        // empty refusal, then two values that leave one behind on the out-stack
        add_cmd(OP_DEQ, 32'h1234_5678);
        add_cmd(OP_ENQ, 32'h8000_0000);
        add_cmd(OP_ENQ, 32'h7FFF_FFFF);
        add_cmd(OP_DEQ, 32'h0);
        // fill the in-stack while the out-stack holds a value
        add_cmd(OP_ENQ, 32'h0000_0000);
        add_cmd(OP_ENQ, 32'hFFFF_FFFF);
        add_cmd(OP_ENQ, 32'hAAAA_AAAA);
        add_cmd(OP_ENQ, 32'h5555_5555);
        for (int i = 4; i < tsq_pkg::STACK_DEPTH; i++)
            add_cmd(OP_ENQ, $urandom);
        // full refusal
        add_cmd(OP_ENQ, 32'hDEAD_BEEF);
        add_cmd(OP_DEQ, $urandom);
        // out-stack empty: whole in-stack moves across
        add_cmd(OP_DEQ, $urandom);

        n = 0;
        while (n < N_RANDOM)
        begin
            case ($urandom_range(0, 4))
                0:       enq_pct = 15;
                1:       enq_pct = 50;
                2:       enq_pct = 75;
                3:       enq_pct = 95;
                default: enq_pct = $urandom_range(0, 100);
            endcase
            len = $urandom_range(20, 80);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(1, 100) <= enq_pct)
                    add_cmd(OP_ENQ, pick_value());
                else
                    add_cmd(OP_DEQ, $urandom);
                n++;
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || start || rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (rsp_q.size() != 0)
        begin
            $display("%0d results never arrived", rsp_q.size());
            fail_cnt += rsp_q.size();
        end

        $display("ran %0d enqueues and %0d dequeues in %0d cycles", n_enq, n_deq, cycle_cnt);
        $display("saw %0d full refusals, %0d empty refusals, %0d stack moves; %0d failures",
                 n_full, n_empty, n_moves, fail_cnt);
        if (fail_cnt == 0)
            $display("two_stack_queue_tb: PASS");
        else
            $display("two_stack_queue_tb: FAIL");
        $finish;
    end

endmodule
